@@ hw/rtl/rpd_pkg.sv @@
// Shared types, constants and helpers for the Rice pixel decoder.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package rpd_pkg;

    localparam int MAX_BLOCK_DEF  = 32;
    localparam int COUNT_BITS_DEF = 25;
    localparam int SEL_BITS       = 5;
    localparam int SEL_RAW        = 26;
    localparam int RAW_BITS       = 32;
    localparam int BUF_BITS       = 40;
    localparam int HELD_BITS      = 6;
    localparam int BS_BITS        = 6;
    localparam int MAX_RESULTS    = 64;
    localparam int NRES_BITS      = 7;
    localparam int RESET_BLOCK    = 32;
    localparam int RESET_COUNT    = 1024;
    localparam int HDR_BYTES      = 4;

    typedef enum logic [0:0] {
        REG_BLOCK_SIZE  = 1'b0,
        REG_PIXEL_COUNT = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        C_PIXEL   = 2'd0,
        C_SHORT   = 2'd1,
        C_OVERRUN = 2'd2,
        C_UNUSED  = 2'd3
    } t_code;

    // decode phase of the bit stream
    typedef enum logic [4:0] {
        PH_SEL  = 5'b00001,
        PH_UNA  = 5'b00010,
        PH_REM  = 5'b00100,
        PH_RAW  = 5'b01000,
        PH_DONE = 5'b10000
    } t_phase;

    // what the byte taken last was used for
    typedef enum logic [1:0] {
        M_HDR = 2'd0,
        M_END = 2'd1,
        M_DEC = 2'd2
    } t_mode;

    typedef struct packed {
        logic  load;
        logic  step;
        logic  run_pix;
        logic  stat;
        t_code code;
        logic  clear;
    } t_cmd;

    typedef struct packed {
        t_mode  mode;
        logic   fin;
        t_phase phase;
        logic   can_step;
        logic   step_emits;
        logic   run_sel;
        logic   run_zero;
        logic   out_free;
        logic   hdr_short;
        logic   repl;
    } t_stat;

    function automatic logic [31:0] unmap(input logic [31:0] d);
        return d[0] ? ~(d >> 1) : (d >> 1);
    endfunction

endpackage

@@ hw/rtl/rpd_datapath.sv @@
// Datapath of the Rice pixel decoder: config, bit buffer, tile state, output register.
// Depends on rpd_pkg; driven by rpd_ctrl through t_cmd, reports through t_stat.
`timescale 1ns / 1ps

module rpd_datapath import rpd_pkg::*; #(
    parameter int MAX_BLOCK  = MAX_BLOCK_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  logic [COUNT_BITS-1:0] i_cfg_data,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_final_byte,
    input  logic                  i_stall,
    input  t_cmd                  i_cmd,
    output t_stat                 o_st,
    output logic                  o_valid,
    output logic [31:0]           o_pixel,
    output logic [1:0]            o_code,
    output logic                  o_last_result
);

    logic [BS_BITS-1:0]    r_block_size;
    logic [COUNT_BITS-1:0] r_pixel_count;

    logic [2:0]            r_hc;
    logic [31:0]           r_prev;
    logic [BUF_BITS-1:0]   r_buf;
    logic [HELD_BITS-1:0]  r_held;
    logic [SEL_BITS-1:0]   r_sel;
    t_phase                r_phase;
    logic [31:0]           r_zrun;
    logic [BS_BITS-1:0]    r_pib;
    logic [BS_BITS-1:0]    r_run_left;
    logic [COUNT_BITS-1:0] r_done;
    logic                  r_fin;
    t_mode                 r_mode;
    logic [NRES_BITS-1:0]  r_nres;

    logic                  r_ovalid;
    logic [31:0]           r_pix;
    t_code                 r_code;
    logic                  r_last;

    logic [COUNT_BITS-1:0] w_pc;
    logic [BS_BITS-1:0]    w_bs;
    logic [SEL_BITS-1:0]   w_fs;
    logic [HELD_BITS-1:0]  w_need;
    logic [HELD_BITS-1:0]  w_sh;
    logic [32:0]           w_mask;
    logic [31:0]           w_field;
    logic [31:0]           w_d;
    logic [31:0]           w_coded_pix;
    logic [COUNT_BITS-1:0] w_done_inc;
    logic                  w_pix_fin;
    logic [COUNT_BITS-1:0] w_left;
    logic [BS_BITS-1:0]    w_k;
    logic [BS_BITS-1:0]    w_pib_dec;
    logic [HELD_BITS+1:0]  w_held_add;
    logic                  w_out_free;

    assign w_pc = (r_pixel_count == '0) ? COUNT_BITS'(1) : r_pixel_count;

    always_comb begin
        if (r_block_size == '0) begin
            w_bs = BS_BITS'(1);
        end else if (r_block_size > BS_BITS'(MAX_BLOCK)) begin
            w_bs = BS_BITS'(MAX_BLOCK);
        end else begin
            w_bs = r_block_size;
        end
    end

    assign w_fs = r_sel - SEL_BITS'(1);

    always_comb begin
        unique case (r_phase)
            PH_SEL:  w_need = HELD_BITS'(SEL_BITS);
            PH_UNA:  w_need = HELD_BITS'(1);
            PH_REM:  w_need = HELD_BITS'(w_fs);
            PH_RAW:  w_need = HELD_BITS'(RAW_BITS);
            default: w_need = '0;
        endcase
    end

    // field of w_need bits sitting just below the fill level
    assign w_sh        = r_held - w_need;
    assign w_mask      = (33'd1 << w_need) - 33'd1;
    assign w_field     = 32'(r_buf >> w_sh) & w_mask[31:0];
    assign w_d         = (r_phase == PH_RAW) ? w_field : ((r_zrun << w_fs) | w_field);
    assign w_coded_pix = unmap(w_d) + r_prev;

    assign w_done_inc = r_done + COUNT_BITS'(1);
    assign w_pix_fin  = (w_done_inc >= w_pc);
    assign w_left     = w_pc - r_done;
    assign w_k        = (w_left < COUNT_BITS'(w_bs)) ? w_left[BS_BITS-1:0] : w_bs;
    assign w_pib_dec  = r_pib - BS_BITS'(1);
    assign w_held_add = (HELD_BITS+2)'(r_held) + (HELD_BITS+2)'(8);
    assign w_out_free = !r_ovalid || !i_stall;

    always_comb begin
        o_st.mode       = r_mode;
        o_st.fin        = r_fin;
        o_st.phase      = r_phase;
        o_st.can_step   = (r_held >= w_need);
        o_st.step_emits = (r_phase == PH_REM) || (r_phase == PH_RAW);
        o_st.run_sel    = (r_phase == PH_SEL) && (w_field[SEL_BITS-1:0] == '0);
        o_st.run_zero   = (r_run_left == '0);
        o_st.out_free   = w_out_free;
        o_st.hdr_short  = (r_hc < 3'(HDR_BYTES));
        o_st.repl       = r_fin && (r_nres == NRES_BITS'(MAX_RESULTS - 1)) && !w_pix_fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size  <= BS_BITS'(RESET_BLOCK);
            r_pixel_count <= COUNT_BITS'(RESET_COUNT);
            r_hc          <= '0;
            r_prev        <= '0;
            r_buf         <= '0;
            r_held        <= '0;
            r_sel         <= '0;
            r_phase       <= PH_SEL;
            r_zrun        <= '0;
            r_pib         <= '0;
            r_run_left    <= '0;
            r_done        <= '0;
            r_fin         <= 1'b0;
            r_mode        <= M_DEC;
            r_nres        <= '0;
            r_ovalid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_addr))
                    REG_BLOCK_SIZE:  r_block_size  <= i_cfg_data[BS_BITS-1:0];
                    REG_PIXEL_COUNT: r_pixel_count <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end

            if (i_cmd.load) begin
                r_fin  <= i_final_byte;
                r_nres <= '0;
                if (r_hc < 3'(HDR_BYTES)) begin
                    r_prev <= {r_prev[23:0], i_data_byte};
                    r_hc   <= r_hc + 3'd1;
                    r_mode <= M_HDR;
                end else if (r_phase == PH_DONE || r_done >= w_pc) begin
                    r_phase <= PH_DONE;
                    r_mode  <= M_END;
                end else begin
                    r_mode <= M_DEC;
                    r_buf  <= {r_buf[BUF_BITS-9:0], i_data_byte};
                    r_held <= (w_held_add > (HELD_BITS+2)'(BUF_BITS)) ?
                              HELD_BITS'(BUF_BITS) : w_held_add[HELD_BITS-1:0];
                end
            end

            if (i_cmd.step) begin
                r_held <= w_sh;
                unique case (r_phase)
                    PH_SEL: begin
                        r_sel <= w_field[SEL_BITS-1:0];
                        if (w_field[SEL_BITS-1:0] == '0) begin
                            r_run_left <= w_k;
                        end else begin
                            r_pib   <= w_k;
                            r_zrun  <= '0;
                            r_phase <= (w_field[SEL_BITS-1:0] == SEL_BITS'(SEL_RAW)) ?
                                       PH_RAW : PH_UNA;
                        end
                    end
                    PH_UNA: begin
                        if (w_field[0]) begin
                            r_phase <= PH_REM;
                        end else begin
                            r_zrun <= r_zrun + 32'd1;
                        end
                    end
                    PH_REM, PH_RAW: begin
                        r_zrun   <= '0;
                        r_prev   <= w_coded_pix;
                        r_done   <= w_done_inc;
                        r_nres   <= r_nres + NRES_BITS'(1);
                        r_ovalid <= 1'b1;
                        r_pix    <= w_coded_pix;
                        r_code   <= C_PIXEL;
                        r_last   <= r_fin && w_pix_fin;
                        r_pib    <= w_pib_dec;
                        if (w_pix_fin) begin
                            r_phase <= PH_DONE;
                        end else if (w_pib_dec == '0) begin
                            r_phase <= PH_SEL;
                        end else begin
                            r_phase <= (r_phase == PH_REM) ? PH_UNA : PH_RAW;
                        end
                    end
                    default: ;
                endcase
            end

            if (i_cmd.run_pix) begin
                r_done     <= w_done_inc;
                r_nres     <= r_nres + NRES_BITS'(1);
                r_run_left <= r_run_left - BS_BITS'(1);
                r_ovalid   <= 1'b1;
                r_pix      <= r_prev;
                r_code     <= C_PIXEL;
                r_last     <= r_fin && w_pix_fin;
                if (w_pix_fin) begin
                    r_phase <= PH_DONE;
                end
            end

            if (i_cmd.stat) begin
                r_ovalid <= 1'b1;
                r_pix    <= '0;
                r_code   <= i_cmd.code;
                r_last   <= 1'b1;
            end

            // end of tile: header count, buffer and decode state back to their reset values, config kept
            if (i_cmd.clear) begin
                r_hc       <= '0;
                r_prev     <= '0;
                r_buf      <= '0;
                r_held     <= '0;
                r_sel      <= '0;
                r_phase    <= PH_SEL;
                r_zrun     <= '0;
                r_pib      <= '0;
                r_run_left <= '0;
                r_done     <= '0;
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_pixel       = r_pix;
    assign o_code        = r_code;
    assign o_last_result = r_last;

endmodule

@@ hw/rtl/rpd_ctrl.sv @@
// Sequencer of the Rice pixel decoder: takes bytes, steps the decode, issues results.
// Depends on rpd_pkg; talks to rpd_datapath through t_cmd / t_stat only.
`timescale 1ns / 1ps

module rpd_ctrl import rpd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_stat i_st,
    output logic  o_stall,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_STEP = 3'b010,
        S_RUN  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd.load    = 1'b0;
        o_cmd.step    = 1'b0;
        o_cmd.run_pix = 1'b0;
        o_cmd.stat    = 1'b0;
        o_cmd.code    = C_PIXEL;
        o_cmd.clear   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_STEP;
                end
            end
            S_STEP: begin
                unique case (i_st.mode)
                    M_HDR, M_END: begin
                        if (!i_st.fin) begin
                            n_state = S_IDLE;
                        end else if (i_st.out_free) begin
                            o_cmd.stat  = 1'b1;
                            o_cmd.clear = 1'b1;
                            if (i_st.mode == M_END) begin
                                o_cmd.code = C_UNUSED;
                            end else begin
                                o_cmd.code = i_st.hdr_short ? C_SHORT : C_OVERRUN;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    M_DEC: begin
                        if (i_st.phase == PH_DONE) begin
                            // on a final byte the last pixel was already flagged
                            o_cmd.clear = i_st.fin;
                            n_state     = S_IDLE;
                        end else if (i_st.can_step) begin
                            if (!i_st.step_emits) begin
                                o_cmd.step = 1'b1;
                                if (i_st.run_sel) begin
                                    n_state = S_RUN;
                                end
                            end else if (i_st.out_free) begin
                                if (i_st.repl) begin
                                    // result budget full: status takes the last slot
                                    o_cmd.stat  = 1'b1;
                                    o_cmd.code  = C_OVERRUN;
                                    o_cmd.clear = 1'b1;
                                    n_state     = S_IDLE;
                                end else begin
                                    o_cmd.step = 1'b1;
                                end
                            end
                        end else if (!i_st.fin) begin
                            n_state = S_IDLE;
                        end else if (i_st.out_free) begin
                            o_cmd.stat  = 1'b1;
                            o_cmd.code  = C_OVERRUN;
                            o_cmd.clear = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_RUN: begin
                if (i_st.run_zero || i_st.phase == PH_DONE) begin
                    n_state = S_STEP;
                end else if (i_st.out_free) begin
                    if (i_st.repl) begin
                        o_cmd.stat  = 1'b1;
                        o_cmd.code  = C_OVERRUN;
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        o_cmd.run_pix = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hw/rtl/rice_pixel_decoder_32_unit.sv @@
// Rice pixel decoder, 32-bit pixels: top level.
// Depends on rpd_pkg, rpd_ctrl and rpd_datapath.
//
// Input channel (i_valid / o_stall) carries one compressed byte per transaction,
// i_final_byte marking the end of a tile. The first four bytes give the start
// pixel; the rest is decoded into pixels on the output channel (o_valid /
// i_stall), closed by a status result (short, overrun, unused bytes) or by
// o_last_result on the final pixel.
// Throughput: one byte is taken, then the decoder steps through it one field a
// cycle (a selector, one unary bit, a remainder or a raw word), run pixels at
// the same rate; a result waits while the output register is full. No new byte
// is taken until the decoder is through with the last one; it returns to idle
// once the buffer is too short for the next field. The unary bit loop sets the
// rate. Before the first result the byte is loaded into the bit buffer and each
// field ahead of the result is stepped; the result is registered in the output
// register. While it is full and i_stall is high, decoding halts at the next
// result and o_stall stays high. Reset (synchronous, i_rst_n low) clears the
// tile state and sets block_size 32 and pixel_count 1024.
// Configuration is to be written through i_cfg_we / i_cfg_addr / i_cfg_data
// while idle by the user; the block itself does not enforce this.
`timescale 1ns / 1ps

module rice_pixel_decoder_32_unit import rpd_pkg::*; #(
    parameter int MAX_BLOCK  = MAX_BLOCK_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  logic [COUNT_BITS-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_final_byte,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [31:0]           o_pixel,
    output logic [1:0]            o_code,
    output logic                  o_last_result
);

    t_cmd  w_cmd;
    t_stat w_st;

    rpd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_st    (w_st),
        .o_stall (o_stall),
        .o_cmd   (w_cmd)
    );

    rpd_datapath #(
        .MAX_BLOCK  (MAX_BLOCK),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_data_byte   (i_data_byte),
        .i_final_byte  (i_final_byte),
        .i_stall       (i_stall),
        .i_cmd         (w_cmd),
        .o_st          (w_st),
        .o_valid       (o_valid),
        .o_pixel       (o_pixel),
        .o_code        (o_code),
        .o_last_result (o_last_result)
    );

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_code != 2'(C_PIXEL)) |-> o_last_result)
        else $error("status result without last flag");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.step, w_cmd.run_pix, w_cmd.clear}))
        else $error("conflicting datapath commands");

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.stat || w_cmd.run_pix || (w_cmd.step && w_st.step_emits)) |-> w_st.out_free)
        else $error("result issued into a full output register");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("byte taken while previous one still in work");

endmodule
